### rtl/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg: shared types and constants of the soft angle limiter
// Widths, register codes, pipeline payload structs and the saturation helper.
// ----------------------------------------------------------------------------
package sal_pkg;

    // angle and derived widths
    localparam int ANGLE_BITS  = 32;
    localparam int ZONE_BITS   = ANGLE_BITS - 1;
    localparam int WIDE_BITS   = ANGLE_BITS + 1;
    localparam int FACTOR_BITS = 16;
    localparam int PROD_BITS   = WIDE_BITS + FACTOR_BITS;
    localparam int CFG_IDX_BITS = 2;

    // soft factor floor, 0.1 in q0.16
    localparam logic [FACTOR_BITS-1:0] FACTOR_MIN = FACTOR_BITS'(6554);

    // register reset values
    localparam logic signed [ANGLE_BITS-1:0] LOWER_RESET = ANGLE_BITS'(-5898240);
    localparam logic signed [ANGLE_BITS-1:0] UPPER_RESET = ANGLE_BITS'(5898240);
    localparam logic [ZONE_BITS-1:0]         ZONE_RESET  = ZONE_BITS'(655360);

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOWER  = 2'd0,
        CFG_UPPER  = 2'd1,
        CFG_ZONE   = 2'd2,
        CFG_ENABLE = 2'd3
    } sal_cfg_idx_t;

    // range status codes
    typedef enum logic [1:0] {
        RS_INSIDE = 2'd0,
        RS_ABOVE  = 2'd1,
        RS_BELOW  = 2'd2
    } sal_status_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] lower;
        logic signed [ANGLE_BITS-1:0] upper;
        logic [ZONE_BITS-1:0]         zone;
        logic                         enable;
    } sal_cfg_t;

    // payload carried through the divider stages
    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] base;
        logic                         neg;
        logic [WIDE_BITS-1:0]         mag;
        logic                         scale;
        logic                         clamp;
        sal_status_t                  status;
        logic signed [ANGLE_BITS-1:0] excess;
        logic [ZONE_BITS-1:0]         rem;
        logic [FACTOR_BITS-1:0]       quo;
    } sal_item_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle;
        sal_status_t                  status;
        logic signed [ANGLE_BITS-1:0] excess;
    } sal_result_t;

    // saturate a wide signed difference to the angle range
    function automatic logic signed [ANGLE_BITS-1:0] sat_angle(
        input logic signed [WIDE_BITS-1:0] x
    );
        logic signed [ANGLE_BITS-1:0] r;
        if (x[WIDE_BITS-1] != x[WIDE_BITS-2])
        begin
            r = x[WIDE_BITS-1] ? {1'b1, {(ANGLE_BITS-1){1'b0}}}
                               : {1'b0, {(ANGLE_BITS-1){1'b1}}};
        end
        else
        begin
            r = x[ANGLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/sal_front.sv
// ----------------------------------------------------------------------------
// sal_front: input capture and range classification
// Three register stages: capture, bound differences, mode selection.
// ----------------------------------------------------------------------------
module sal_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  sal_pkg::sal_cfg_t                    cfg,
    input  logic                                 up_valid,
    input  logic signed [sal_pkg::ANGLE_BITS-1:0] target_angle,
    input  logic signed [sal_pkg::ANGLE_BITS-1:0] present_angle,
    output logic                                 dn_valid,
    output sal_pkg::sal_item_t                   dn_item
);

    localparam int A = sal_pkg::ANGLE_BITS;
    localparam int W = sal_pkg::WIDE_BITS;

    logic                  s1_valid_reg;
    logic signed [A-1:0]   s1_target_reg;
    logic signed [A-1:0]   s1_present_reg;

    logic                  s2_valid_reg;
    logic signed [A-1:0]   s2_target_reg;
    logic signed [A-1:0]   s2_present_reg;
    logic                  s2_lo_reg;
    logic                  s2_hi_reg;
    logic signed [W-1:0]   s2_dmin_reg;
    logic signed [W-1:0]   s2_dmax_reg;
    logic signed [W-1:0]   s2_step_reg;

    logic signed [W-1:0]   present_w;
    logic signed [W-1:0]   target_w;
    logic signed [W-1:0]   lower_w;
    logic signed [W-1:0]   upper_w;
    logic                  s2_lo_next;
    logic                  s2_hi_next;
    logic signed [W-1:0]   s2_dmin_next;
    logic signed [W-1:0]   s2_dmax_next;
    logic signed [W-1:0]   s2_step_next;

    logic                  in_range;
    logic                  neg;
    logic                  nonzero;
    logic [W-1:0]          zone_w;
    logic                  scale_dn;
    logic                  scale_up;
    logic signed [W-1:0]   dmax_neg;

    logic                  item_valid_reg;
    sal_pkg::sal_item_t    item_reg;
    sal_pkg::sal_item_t    item_next;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            item_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg   <= up_valid;
            s2_valid_reg   <= s1_valid_reg;
            item_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: capture the transaction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_target_reg  <= target_angle;
            s1_present_reg <= present_angle;
        end
    end

    // stage 2: bound tests and differences
    always_comb
    begin
        present_w    = {s1_present_reg[A-1], s1_present_reg};
        target_w     = {s1_target_reg[A-1], s1_target_reg};
        lower_w      = {cfg.lower[A-1], cfg.lower};
        upper_w      = {cfg.upper[A-1], cfg.upper};
        s2_lo_next   = s1_present_reg < cfg.lower;
        s2_hi_next   = s1_present_reg > cfg.upper;
        s2_dmin_next = present_w - lower_w;
        s2_dmax_next = upper_w - present_w;
        s2_step_next = target_w - present_w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_target_reg  <= s1_target_reg;
            s2_present_reg <= s1_present_reg;
            s2_lo_reg      <= s2_lo_next;
            s2_hi_reg      <= s2_hi_next;
            s2_dmin_reg    <= s2_dmin_next;
            s2_dmax_reg    <= s2_dmax_next;
            s2_step_reg    <= s2_step_next;
        end
    end

    // stage 3: pick mode, soft zone distance and status
    always_comb
    begin
        in_range = !s2_lo_reg && !s2_hi_reg;
        neg      = s2_step_reg[W-1];
        nonzero  = |s2_step_reg;
        zone_w   = {2'b00, cfg.zone};
        scale_dn = cfg.enable && in_range && neg
                   && ($unsigned(s2_dmin_reg) < zone_w);
        scale_up = cfg.enable && in_range && !neg && nonzero
                   && ($unsigned(s2_dmax_reg) < zone_w);
        dmax_neg = -s2_dmax_reg;

        item_next.neg   = neg;
        item_next.mag   = neg ? (~s2_step_reg + 1'b1) : s2_step_reg;
        item_next.scale = scale_dn || scale_up;
        item_next.clamp = cfg.enable && in_range;
        item_next.quo   = '0;
        if (scale_dn)
        begin
            item_next.rem = s2_dmin_reg[sal_pkg::ZONE_BITS-1:0];
        end
        else if (scale_up)
        begin
            item_next.rem = s2_dmax_reg[sal_pkg::ZONE_BITS-1:0];
        end
        else
        begin
            item_next.rem = '0;
        end

        priority if (!cfg.enable)
        begin
            item_next.status = sal_pkg::RS_INSIDE;
            item_next.excess = '0;
            item_next.base   = s2_target_reg;
        end
        else if (s2_lo_reg)
        begin
            item_next.status = sal_pkg::RS_BELOW;
            item_next.excess = sal_pkg::sat_angle(s2_dmin_reg);
            item_next.base   = cfg.lower;
        end
        else if (s2_hi_reg)
        begin
            item_next.status = sal_pkg::RS_ABOVE;
            item_next.excess = sal_pkg::sat_angle(dmax_neg);
            item_next.base   = cfg.upper;
        end
        else
        begin
            item_next.status = sal_pkg::RS_INSIDE;
            item_next.excess = '0;
            item_next.base   = item_next.scale ? s2_present_reg : s2_target_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = item_valid_reg;
    assign dn_item  = item_reg;

endmodule

### rtl/sal_div_stage.sv
// ----------------------------------------------------------------------------
// sal_div_stage: one restoring division step of the soft factor
// Produces one quotient bit of distance * 2^16 / soft_zone per stage.
// ----------------------------------------------------------------------------
module sal_div_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [sal_pkg::ZONE_BITS-1:0]   zone,
    input  logic                            up_valid,
    input  sal_pkg::sal_item_t              up_item,
    output logic                            dn_valid,
    output sal_pkg::sal_item_t              dn_item
);

    localparam int Z = sal_pkg::ZONE_BITS;
    localparam int F = sal_pkg::FACTOR_BITS;

    logic               valid_reg;
    sal_pkg::sal_item_t item_reg;
    sal_pkg::sal_item_t item_next;
    logic [Z:0]         rem2;
    logic [Z:0]         diff;
    logic               ge;

    // shift remainder, trial subtract, keep quotient bit
    always_comb
    begin
        rem2          = {up_item.rem, 1'b0};
        diff          = rem2 - {1'b0, zone};
        ge            = rem2 >= {1'b0, zone};
        item_next     = up_item;
        item_next.rem = ge ? diff[Z-1:0] : rem2[Z-1:0];
        item_next.quo = {up_item.quo[F-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

### rtl/sal_back.sv
// ----------------------------------------------------------------------------
// sal_back: step scaling and hard clamp
// Multiply stage, add stage, then the clamp feeding the output register.
// ----------------------------------------------------------------------------
module sal_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  sal_pkg::sal_cfg_t   cfg,
    input  logic                up_valid,
    input  sal_pkg::sal_item_t  up_item,
    output logic                fin_valid,
    output sal_pkg::sal_result_t fin
);

    localparam int A = sal_pkg::ANGLE_BITS;
    localparam int W = sal_pkg::WIDE_BITS;
    localparam int F = sal_pkg::FACTOR_BITS;
    localparam int P = sal_pkg::PROD_BITS;

    logic [F-1:0]          factor;
    logic [P-1:0]          m_prod_next;

    logic                  m_valid_reg;
    logic [P-1:0]          m_prod_reg;
    logic signed [A-1:0]   m_base_reg;
    logic                  m_neg_reg;
    logic                  m_scale_reg;
    logic                  m_clamp_reg;
    sal_pkg::sal_status_t  m_status_reg;
    logic signed [A-1:0]   m_excess_reg;

    logic signed [W:0]     base_w;
    logic signed [W:0]     scaled_w;
    logic signed [W:0]     sum_wide;
    logic signed [A-1:0]   a_sum_next;

    logic                  a_valid_reg;
    logic signed [A-1:0]   a_sum_reg;
    logic                  a_clamp_reg;
    sal_pkg::sal_status_t  a_status_reg;
    logic signed [A-1:0]   a_excess_reg;

    // soft factor floor and step magnitude product
    always_comb
    begin
        factor      = (up_item.quo < sal_pkg::FACTOR_MIN) ? sal_pkg::FACTOR_MIN
                                                          : up_item.quo;
        m_prod_next = P'(up_item.mag) * P'(factor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= up_valid;
            a_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_prod_reg   <= m_prod_next;
            m_base_reg   <= up_item.base;
            m_neg_reg    <= up_item.neg;
            m_scale_reg  <= up_item.scale;
            m_clamp_reg  <= up_item.clamp;
            m_status_reg <= up_item.status;
            m_excess_reg <= up_item.excess;
        end
    end

    // apply the truncated scaled step to the present angle, or pass the base through when not scaling
    always_comb
    begin
        base_w   = {{2{m_base_reg[A-1]}}, m_base_reg};
        scaled_w = {1'b0, m_prod_reg[P-1:F]};
        if (!m_scale_reg)
        begin
            sum_wide = base_w;
        end
        else if (m_neg_reg)
        begin
            sum_wide = base_w - scaled_w;
        end
        else
        begin
            sum_wide = base_w + scaled_w;
        end
        // result lies between present and target, so it fits the angle width
        a_sum_next = sum_wide[A-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sum_reg    <= a_sum_next;
            a_clamp_reg  <= m_clamp_reg;
            a_status_reg <= m_status_reg;
            a_excess_reg <= m_excess_reg;
        end
    end

    // hard clamp to the bounds
    always_comb
    begin
        fin.status = a_status_reg;
        fin.excess = a_excess_reg;
        priority if (a_clamp_reg && (a_sum_reg < cfg.lower))
        begin
            fin.angle = cfg.lower;
        end
        else if (a_clamp_reg && (a_sum_reg > cfg.upper))
        begin
            fin.angle = cfg.upper;
        end
        else
        begin
            fin.angle = a_sum_reg;
        end
    end

    assign fin_valid = a_valid_reg;

endmodule

### rtl/soft_angle_limiter_top.sv
// ----------------------------------------------------------------------------
// soft_angle_limiter_top: soft position limit with hard clamp
// Angle command limiter with slow-down band near each bound and status output.
// ----------------------------------------------------------------------------
// The limiter takes one angle pair per clock while in_stall is low and returns
// one result per pair, in order. The pipeline is the soft factor divider, which
// resolves one quotient bit per pipeline stage over 16 stages, plus three
// front stages, a multiply stage, an add stage and the output register. A
// two-entry output buffer (output register plus skid register) lets the block
// keep accepting while a finished result waits; in_stall rises only when both
// are full. Configuration writes are always ready and take effect at once; they
// should be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module soft_angle_limiter_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sal_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [sal_pkg::ANGLE_BITS-1:0]        cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [sal_pkg::ANGLE_BITS-1:0] target_angle,
    input  logic signed [sal_pkg::ANGLE_BITS-1:0] present_angle,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [sal_pkg::ANGLE_BITS-1:0] bounded_angle,
    output logic [1:0]                            range_status,
    output logic signed [sal_pkg::ANGLE_BITS-1:0] excess
);

    localparam int STAGES = sal_pkg::FACTOR_BITS;

    logic signed [sal_pkg::ANGLE_BITS-1:0] lower_reg;
    logic signed [sal_pkg::ANGLE_BITS-1:0] upper_reg;
    logic [sal_pkg::ZONE_BITS-1:0]         zone_reg;
    logic                                  enable_reg;
    sal_pkg::sal_cfg_t                     cfg;

    logic                 en;
    logic                 div_valid [0:STAGES];
    sal_pkg::sal_item_t   div_item  [0:STAGES];
    logic                 fin_valid;
    sal_pkg::sal_result_t fin;

    logic                 out_valid_reg;
    sal_pkg::sal_result_t out_res_reg;
    logic                 skid_valid_reg;
    sal_pkg::sal_result_t skid_res_reg;
    logic                 out_free;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg  <= sal_pkg::LOWER_RESET;
            upper_reg  <= sal_pkg::UPPER_RESET;
            zone_reg   <= sal_pkg::ZONE_RESET;
            enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sal_pkg::sal_cfg_idx_t'(cfg_index))
                sal_pkg::CFG_LOWER:  lower_reg  <= cfg_data;
                sal_pkg::CFG_UPPER:  upper_reg  <= cfg_data;
                sal_pkg::CFG_ZONE:   zone_reg   <= cfg_data[sal_pkg::ZONE_BITS-1:0];
                sal_pkg::CFG_ENABLE: enable_reg <= cfg_data[0];
            endcase
        end
    end

    always_comb
    begin
        cfg.lower  = lower_reg;
        cfg.upper  = upper_reg;
        cfg.zone   = zone_reg;
        cfg.enable = enable_reg;
    end

    // pipeline advances whenever the skid register is empty
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    sal_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .cfg           (cfg),
        .up_valid      (in_valid),
        .target_angle  (target_angle),
        .present_angle (present_angle),
        .dn_valid      (div_valid[0]),
        .dn_item       (div_item[0])
    );

    // divider chain, one quotient bit per stage
    for (genvar i = 0; i < STAGES; i++)
    begin : g_div
        sal_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .zone     (zone_reg),
            .up_valid (div_valid[i]),
            .up_item  (div_item[i]),
            .dn_valid (div_valid[i+1]),
            .dn_item  (div_item[i+1])
        );
    end

    sal_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .up_valid  (div_valid[STAGES]),
        .up_item   (div_item[STAGES]),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    // output register with skid buffer
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= fin_valid;
        end
        else if (fin_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (out_free)
        begin
            out_res_reg <= fin;
        end
        else
        begin
            skid_res_reg <= fin;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bounded_angle = out_res_reg.angle;
    assign range_status  = out_res_reg.status;
    assign excess        = out_res_reg.excess;

    // a buffered transaction always sits behind a shown one
    a_skid_behind_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("skid register holds a transaction while output is empty");

    // inside or disabled reports no excess
    a_inside_no_excess: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.status == sal_pkg::RS_INSIDE))
            |-> (out_res_reg.excess == '0)
    ) else $error("nonzero excess with inside status");

    // above the upper bound gives a positive excess
    a_above_positive: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.status == sal_pkg::RS_ABOVE))
            |-> (out_res_reg.excess > 0)
    ) else $error("above-bound status without positive excess");

    // below the lower bound gives a negative excess
    a_below_negative: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.status == sal_pkg::RS_BELOW))
            |-> (out_res_reg.excess < 0)
    ) else $error("below-bound status without negative excess");

endmodule
